[hw/rtl/gtbm_pkg.sv]
// ----------------------------------------------------------------------------
// gtbm_pkg
// Shared widths, limits and register codes of the grouped tile block mapper.
// ----------------------------------------------------------------------------
package gtbm_pkg;

    localparam int ID_W          = 20;
    localparam int DIM_W         = 11;
    localparam int WGC_W         = 21;
    localparam int DIV_W         = 21;
    localparam int CHIP_SH       = 3;
    localparam int NUM_CHIPLETS  = 8;
    localparam int MAX_TILE_ROWS = 1024;
    localparam int MAX_TILE_COLS = 1024;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 21;
    localparam int FIRST_W       = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_ROWS  = 3'd0,
        REG_TILE_COLS  = 3'd1,
        REG_GROUP_ROWS = 3'd2,
        REG_WG_COUNT   = 3'd3,
        REG_SWIZZLE    = 3'd4
    } cfg_reg_t;

endpackage

[hw/rtl/grouped_tile_block_mapper.sv]
// ----------------------------------------------------------------------------
// grouped_tile_block_mapper
// Maps a workgroup id to its output tile (row, column), with optional chiplet
// remap and grouped row-band order.
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  input   | in_valid, in_stall, block_id            | request in
//  output  | out_valid, out_stall, tile_row/col, oor | request out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
//  One request per cycle while the output is not stalled; two 21-stage restoring
//  dividers (band split, then row/column split) and five other stages.
//  A stall on the output freezes the whole pipeline; nothing is dropped.
//  Reset clears valid bits and restores register defaults; cfg_ready is high.
// ----------------------------------------------------------------------------
module grouped_tile_block_mapper
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gtbm_pkg::ID_W-1:0]         block_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gtbm_pkg::DIM_W-1:0]        tile_row,
    output logic [gtbm_pkg::DIM_W-1:0]        tile_col,
    output logic                              out_of_range,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gtbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gtbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DW   = gtbm_pkg::DIV_W;
    localparam int NDIV = gtbm_pkg::DIV_W + 1;
    localparam int NV   = 2 * NDIV + 2;

    // configuration registers
    logic [gtbm_pkg::DIM_W-1:0] tile_rows_reg;
    logic [gtbm_pkg::DIM_W-1:0] tile_cols_reg;
    logic [gtbm_pkg::DIM_W-1:0] group_rows_reg;
    logic [gtbm_pkg::WGC_W-1:0] wg_count_reg;
    logic                       swizzle_reg;
    logic [gtbm_pkg::DIM_W-1:0] cfg_rows;
    logic [gtbm_pkg::DIM_W-1:0] cfg_cols;

    assign cfg_ready = 1'b1;
    assign cfg_rows  = (cfg_data[gtbm_pkg::DIM_W-1:0] > gtbm_pkg::DIM_W'(gtbm_pkg::MAX_TILE_ROWS))
                     ? gtbm_pkg::DIM_W'(gtbm_pkg::MAX_TILE_ROWS) : cfg_data[gtbm_pkg::DIM_W-1:0];
    assign cfg_cols  = (cfg_data[gtbm_pkg::DIM_W-1:0] > gtbm_pkg::DIM_W'(gtbm_pkg::MAX_TILE_COLS))
                     ? gtbm_pkg::DIM_W'(gtbm_pkg::MAX_TILE_COLS) : cfg_data[gtbm_pkg::DIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_rows_reg  <= gtbm_pkg::DIM_W'(1);
            tile_cols_reg  <= gtbm_pkg::DIM_W'(1);
            group_rows_reg <= gtbm_pkg::DIM_W'(4);
            wg_count_reg   <= gtbm_pkg::WGC_W'(1);
            swizzle_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gtbm_pkg::REG_TILE_ROWS:  tile_rows_reg  <= cfg_rows;
                gtbm_pkg::REG_TILE_COLS:  tile_cols_reg  <= cfg_cols;
                gtbm_pkg::REG_GROUP_ROWS: group_rows_reg <= cfg_rows;
                gtbm_pkg::REG_WG_COUNT:   wg_count_reg   <= cfg_data[gtbm_pkg::WGC_W-1:0];
                gtbm_pkg::REG_SWIZZLE:    swizzle_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // derived configuration terms (user keeps static while requests in flight)
    logic [2*gtbm_pkg::DIM_W-1:0] per_band;
    logic [DW-1:0]                div_a;
    logic                         wgc_ok;
    logic                         cfg_bad;

    assign per_band = group_rows_reg * tile_cols_reg;
    assign div_a    = !swizzle_reg ? {DW{1'b1}}
                    : (per_band == '0) ? DW'(1) : per_band[DW-1:0];
    assign wgc_ok   = (wg_count_reg >= gtbm_pkg::WGC_W'(gtbm_pkg::NUM_CHIPLETS))
                   && (wg_count_reg[gtbm_pkg::CHIP_SH-1:0] == '0);
    assign cfg_bad  = (tile_rows_reg == '0) || (tile_cols_reg == '0)
                   || (swizzle_reg && (group_rows_reg == '0));

    // pipeline control: everything moves together unless the output is held
    logic              adv;
    logic [NV-1:0]     vld_reg;
    logic              out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // stage registers
    logic [gtbm_pkg::ID_W-1:0]     id_reg;
    logic [DW-1:0]                 ar_reg [NDIV];
    logic [DW-1:0]                 aq_reg [NDIV];
    logic [gtbm_pkg::FIRST_W-1:0]  first_reg;
    logic [DW-1:0]                 off_reg;
    logic [DW-1:0]                 br_reg [NDIV];
    logic [DW-1:0]                 bq_reg [NDIV];
    logic [DW-1:0]                 bd_reg [NDIV];
    logic [gtbm_pkg::DIM_W-1:0]    bf_reg [NDIV];
    logic                          be_reg [NDIV];
    logic [gtbm_pkg::DIM_W-1:0]    row_reg;
    logic [gtbm_pkg::DIM_W-1:0]    col_reg;
    logic                          oor_reg;

    // chiplet remap
    logic [DW-1:0] remap_next;
    always_comb
    begin
        remap_next = DW'(id_reg);
        if (swizzle_reg && wgc_ok)
            remap_next = DW'(id_reg[gtbm_pkg::CHIP_SH-1:0]
                             * wg_count_reg[gtbm_pkg::WGC_W-1:gtbm_pkg::CHIP_SH])
                       + DW'(id_reg[gtbm_pkg::ID_W-1:gtbm_pkg::CHIP_SH]);
    end

    // divider steps
    logic [DW-1:0] ar_next [NDIV];
    logic [DW-1:0] aq_next [NDIV];
    logic [DW-1:0] br_next [NDIV];
    logic [DW-1:0] bq_next [NDIV];
    always_comb
    begin
        logic [DW:0] ta;
        logic [DW:0] tb;
        ar_next[0] = '0;
        aq_next[0] = remap_next;
        br_next[0] = '0;
        bq_next[0] = off_reg;
        for (int i = 1; i < NDIV; i++)
        begin
            ta = {ar_reg[i-1], aq_reg[i-1][DW-1]};
            aq_next[i] = {aq_reg[i-1][DW-2:0], 1'b0};
            if (ta >= {1'b0, div_a})
            begin
                ar_next[i]    = DW'(ta - {1'b0, div_a});
                aq_next[i][0] = 1'b1;
            end
            else
                ar_next[i] = ta[DW-1:0];
            tb = {br_reg[i-1], bq_reg[i-1][DW-1]};
            bq_next[i] = {bq_reg[i-1][DW-2:0], 1'b0};
            if (tb >= {1'b0, bd_reg[i-1]})
            begin
                br_next[i]    = DW'(tb - {1'b0, bd_reg[i-1]});
                bq_next[i][0] = 1'b1;
            end
            else
                br_next[i] = tb[DW-1:0];
        end
    end

    // band start, then span and divisor for the row/column split
    logic [gtbm_pkg::FIRST_W-1:0] first_next;
    logic                         empty_b;
    logic [gtbm_pkg::FIRST_W-1:0] band_end;
    logic [gtbm_pkg::DIM_W-1:0]   span_b;
    logic [DW-1:0]                div_b;

    assign first_next = gtbm_pkg::FIRST_W'(aq_reg[NDIV-1] * group_rows_reg);
    assign band_end   = first_reg + gtbm_pkg::FIRST_W'(group_rows_reg);
    always_comb
    begin
        empty_b = swizzle_reg && (first_reg >= gtbm_pkg::FIRST_W'(tile_rows_reg));
        span_b  = (band_end <= gtbm_pkg::FIRST_W'(tile_rows_reg)) ? group_rows_reg
                : tile_rows_reg - first_reg[gtbm_pkg::DIM_W-1:0];
        if (!swizzle_reg)
            div_b = (tile_cols_reg == '0) ? DW'(1) : DW'(tile_cols_reg);
        else if (empty_b || span_b == '0)
            div_b = DW'(1);
        else
            div_b = DW'(span_b);
    end

    // final placement and range check
    logic [DW:0] row_full;
    logic [DW:0] col_full;
    logic        bad_f;
    always_comb
    begin
        if (swizzle_reg)
        begin
            row_full = (DW+1)'(bf_reg[NDIV-1]) + (DW+1)'(br_reg[NDIV-1]);
            col_full = (DW+1)'(bq_reg[NDIV-1]);
        end
        else
        begin
            row_full = (DW+1)'(bq_reg[NDIV-1]);
            col_full = (DW+1)'(br_reg[NDIV-1]);
        end
        bad_f = cfg_bad || be_reg[NDIV-1]
             || (row_full >= (DW+1)'(tile_rows_reg))
             || (col_full >= (DW+1)'(tile_cols_reg));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NV-2:0], in_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            id_reg <= block_id;
            for (int i = 0; i < NDIV; i++)
            begin
                ar_reg[i] <= ar_next[i];
                aq_reg[i] <= aq_next[i];
            end
            first_reg <= swizzle_reg ? first_next : '0;
            off_reg   <= ar_reg[NDIV-1];
            br_reg[0] <= br_next[0];
            bq_reg[0] <= bq_next[0];
            bd_reg[0] <= div_b;
            bf_reg[0] <= first_reg[gtbm_pkg::DIM_W-1:0];
            be_reg[0] <= empty_b;
            for (int i = 1; i < NDIV; i++)
            begin
                br_reg[i] <= br_next[i];
                bq_reg[i] <= bq_next[i];
                bd_reg[i] <= bd_reg[i-1];
                bf_reg[i] <= bf_reg[i-1];
                be_reg[i] <= be_reg[i-1];
            end
            row_reg <= bad_f ? tile_rows_reg : row_full[gtbm_pkg::DIM_W-1:0];
            col_reg <= bad_f ? tile_cols_reg : col_full[gtbm_pkg::DIM_W-1:0];
            oor_reg <= bad_f;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tile_row     = row_reg;
    assign tile_col     = col_reg;
    assign out_of_range = oor_reg;

endmodule
